/* src/bpa_pkg.sv */
// Shared types and constants of the block pool allocator.
`timescale 1ns / 1ps

package bpa_pkg;

   // field widths fixed by the beat formats
   localparam int ENTRY_W = 6;
   localparam int CFG_W   = 7;
   localparam int STAT_W  = 2;

   // request actions
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // response status codes
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE     = 2'd2;

   // reset value of the pool size register
   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

   typedef struct packed {
      logic               action;
      logic [ENTRY_W-1:0] entry_to_free;
   } req_type;

   typedef struct packed {
      logic               granted;
      logic [ENTRY_W-1:0] entry_given;
      logic [STAT_W-1:0]  status;
   } rsp_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_POP_RD,
      S_POP_WR,
      S_RESULT
   } state_type;

endpackage

/* src/bpa_ram.sv */
// Simple dual-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module bpa_ram #(
   parameter int WIDTH  = 1,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/block_pool_allocator_with_cache.sv */
// Top level of the block pool allocator: sequencer, free-mark RAM and ready stack.
`timescale 1ns / 1ps
//
// Block pool allocator with a refill stack.
// Request channel (req_valid/req_ready, req_data): one beat asks either to
// allocate a pool entry or to free the entry it names. Response channel
// (rsp_valid/rsp_ready, rsp_data): exactly one beat per request, in order,
// with the entry granted and a status (ok, exhausted, free out of range).
// csr_wr_en/csr_wr_data write the pool size; write it only while idle.
// Free marks live in a POOL_DEPTH x 1 RAM, ready entries in a
// STACK_DEPTH-deep stack RAM; both have a registered read port.
// A free sets the mark of an entry in range and pushes the entry if the
// stack has room. An allocate pops the stack and clears the mark of the
// entry handed out; with an empty stack a refill scan first reads one
// free mark per cycle and pushes free entries until the stack is full or
// the end of the pool in use; if the stack stays empty, it is exhausted.
// Only one request is in the sequencer at a time.
// After reset a clearing pass over the whole RAM sets every free mark;
// req_ready stays low during it. The response sits in an output register:
// the next request is accepted while it waits, and a stalled receiver only
// holds the sequencer once a second response is ready to be loaded.

module block_pool_allocator_with_cache #(
   parameter int POOL_DEPTH  = 64,
   parameter int STACK_DEPTH = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  bpa_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bpa_pkg::rsp_type          rsp_data,
   input  logic                      csr_wr_en,
   input  logic [bpa_pkg::CFG_W-1:0] csr_wr_data
);

   import bpa_pkg::*;

   localparam int IDX_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int SCAN_W = $clog2(POOL_DEPTH + 1);
   localparam int CMP_W  = (SCAN_W > CFG_W) ? SCAN_W : CFG_W;
   localparam int SP_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   state_type          state_ff, state_in;
   logic [CFG_W-1:0]   cfg_ff, cfg_in;
   req_type            req_ff, req_in;
   rsp_type            res_ff, res_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SCAN_W-1:0]  scan_ff, scan_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;

   logic [CMP_W-1:0]   cfg_wide;
   logic [CMP_W-1:0]   psize_wide;
   logic [SCAN_W-1:0]  psize;
   logic               stack_room;
   logic               stack_empty;
   logic               issue;
   logic               push_scan;
   logic               in_range;
   logic               slot_free;

   logic               mark_wr_en;
   logic [IDX_W-1:0]   mark_wr_addr;
   logic [0:0]         mark_wr_data;
   logic               mark_rd_en;
   logic [IDX_W-1:0]   mark_rd_addr;
   logic [0:0]         mark_rd_data;

   logic               stk_wr_en;
   logic [SP_W-1:0]    stk_wr_addr;
   logic [IDX_W-1:0]   stk_wr_data;
   logic               stk_rd_en;
   logic [SP_W-1:0]    stk_rd_addr;
   logic [IDX_W-1:0]   stk_rd_data;

   // free marks, one bit per pool entry
   bpa_ram #(
      .WIDTH  (1),
      .DEPTH  (POOL_DEPTH),
      .ADDR_W (IDX_W)
   ) u_marks (
      .clock   (clock),
      .wr_en   (mark_wr_en),
      .wr_addr (mark_wr_addr),
      .wr_data (mark_wr_data),
      .rd_en   (mark_rd_en),
      .rd_addr (mark_rd_addr),
      .rd_data (mark_rd_data)
   );

   // ready stack of free entry numbers
   bpa_ram #(
      .WIDTH  (IDX_W),
      .DEPTH  (STACK_DEPTH),
      .ADDR_W (SP_W)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   // effective pool size, clamped to the RAM depth
   assign cfg_wide   = CMP_W'(cfg_ff);
   assign psize_wide = (cfg_wide > CMP_W'(POOL_DEPTH)) ? CMP_W'(POOL_DEPTH) : cfg_wide;
   assign psize      = SCAN_W'(psize_wide);

   assign stack_room  = (count_ff < CNT_W'(STACK_DEPTH));
   assign stack_empty = (count_ff == '0);
   assign issue       = (state_ff == S_SCAN) && (scan_ff < psize) && stack_room;
   assign push_scan   = (state_ff == S_SCAN) && pend_ff && mark_rd_data[0] && stack_room;
   assign in_range    = (CMP_W'(req_ff.entry_to_free) < psize_wide);
   assign slot_free   = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == IDX_W'(POOL_DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (req_ff.action == ACT_FREE) state_in = S_RESULT;
            else if (stack_empty)          state_in = S_SCAN;
            else                           state_in = S_POP_RD;
         end
         S_SCAN: begin
            if (!issue && !pend_ff) state_in = S_POP_RD;
         end
         S_POP_RD: begin
            if (stack_empty) state_in = S_RESULT;
            else             state_in = S_POP_WR;
         end
         S_POP_WR: begin
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (slot_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // datapath and memory controls
   always_comb begin
      cfg_in       = csr_wr_en ? csr_wr_data : cfg_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      pend_in      = 1'b0;
      pend_idx_in  = IDX_W'(scan_ff);
      clr_in       = clr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = (state_ff == S_IDLE);

      mark_wr_en   = 1'b0;
      mark_wr_addr = IDX_W'(req_ff.entry_to_free);
      mark_wr_data = 1'b1;
      mark_rd_en   = issue;
      mark_rd_addr = IDX_W'(scan_ff);
      stk_wr_en    = 1'b0;
      stk_wr_addr  = SP_W'(count_ff);
      stk_wr_data  = IDX_W'(req_ff.entry_to_free);
      stk_rd_en    = 1'b0;
      stk_rd_addr  = SP_W'(count_ff - 1'b1);

      case (state_ff)
         S_CLEAR: begin
            // set one free mark per cycle
            mark_wr_en   = 1'b1;
            mark_wr_addr = clr_ff;
            clr_in       = clr_ff + 1'b1;
         end
         S_IDLE: begin
            if (req_valid) req_in = req_data;
         end
         S_DECODE: begin
            res_in  = '{granted: 1'b0, entry_given: '0, status: ST_OK};
            scan_in = '0;
            if (req_ff.action == ACT_FREE) begin
               if (in_range) begin
                  mark_wr_en = 1'b1;
                  if (stack_room) begin
                     stk_wr_en = 1'b1;
                     count_in  = count_ff + 1'b1;
                  end
               end else begin
                  res_in.status = ST_RANGE;
               end
            end
         end
         S_SCAN: begin
            // issue one mark read per cycle, push free entries as they return
            if (issue) begin
               pend_in = 1'b1;
               scan_in = scan_ff + 1'b1;
            end
            if (push_scan) begin
               stk_wr_en   = 1'b1;
               stk_wr_data = pend_idx_ff;
               count_in    = count_ff + 1'b1;
            end
         end
         S_POP_RD: begin
            if (stack_empty) begin
               res_in.status = ST_EXHAUSTED;
            end else begin
               stk_rd_en = 1'b1;
               count_in  = count_ff - 1'b1;
            end
         end
         S_POP_WR: begin
            // clear the mark of the entry handed out
            mark_wr_en   = 1'b1;
            mark_wr_addr = stk_rd_data;
            mark_wr_data = 1'b0;
            res_in       = '{granted: 1'b1, entry_given: ENTRY_W'(stk_rd_data), status: ST_OK};
         end
         S_RESULT: begin
            if (slot_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cfg_ff       <= CFG_RESET;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // stack fill never passes its depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("ready stack count beyond depth");

   // no request is taken during the clearing pass
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready)
      else $error("request accepted while clearing free marks");

   // a granted beat always reports ok
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.granted) |-> (rsp_data.status == ST_OK))
      else $error("granted response with error status");

   // a pop is only issued with a non-empty stack and is followed by the mark update
   assert property (@(posedge clock) disable iff (reset)
      stk_rd_en |=> (state_ff == S_POP_WR))
      else $error("stack read without mark update");

   // refill reads stay inside the pool in use
   assert property (@(posedge clock) disable iff (reset)
      mark_rd_en |-> (scan_ff < psize))
      else $error("refill scan beyond pool size");

endmodule
